// ===== rtl/met_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the Mandelbrot escape-time core.
// No dependencies; used by met_mul, met_core and mandelbrot_escape_time_core.
package met_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int Z_WIDTH_DEF   = 48;
    localparam int IN_FRAC       = 24;
    localparam int C_WIDTH       = 32;
    localparam int LIMB_W        = 32;

    localparam int ITER_W     = 15;
    localparam int RADIUS_W   = 10;
    localparam int RSQ_W      = 2 * RADIUS_W;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = CFG_ADDR_W'(1);

    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1000);
    localparam logic [RSQ_W-1:0]  RSQ_RST      = RSQ_W'(1000 * 1000);

    typedef struct packed {
        logic [ITER_W-1:0] max_iter;
        logic [RSQ_W-1:0]  radius_sq;
    } t_met_cfg;

    typedef struct packed {
        logic              escaped;
        logic [ITER_W-1:0] iterations;
    } t_met_res;

endpackage

// ===== rtl/met_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier: one 32x32 partial product per cycle, accumulated.
// Depends on met_pkg.
module met_mul
    import met_pkg::*;
#(
    parameter int Z_WIDTH = Z_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [Z_WIDTH-1:0]     i_a,
    input  logic [Z_WIDTH-1:0]     i_b,
    output logic                   o_done,
    output logic [2*Z_WIDTH-1:0]   o_prod
);

    localparam int NL = (Z_WIDTH + LIMB_W - 1) / LIMB_W;
    localparam int PW = NL * LIMB_W;
    localparam int IW = (NL > 1) ? $clog2(NL) : 1;
    localparam int SW = (NL > 1) ? $clog2(2 * NL - 1) : 1;

    logic [PW-1:0]       r_a;
    logic [PW-1:0]       r_b;
    logic [IW-1:0]       r_ia;
    logic [IW-1:0]       r_ib;
    logic                r_run;
    logic [2*LIMB_W-1:0] r_pp;
    logic [SW-1:0]       r_pp_sh;
    logic                r_pp_vld;
    logic                r_pp_last;
    logic [2*PW-1:0]     r_acc;
    logic                r_done;

    logic                last_pp;
    logic [2*PW-1:0]     pp_ext;

    assign last_pp = (r_ia == IW'(NL - 1)) && (r_ib == IW'(NL - 1));
    assign pp_ext  = {{(2*PW-2*LIMB_W){1'b0}}, r_pp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_run;
            r_pp_last <= r_run && last_pp;
            r_done    <= r_pp_vld && r_pp_last;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last_pp) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PW'(i_a);
            r_b   <= PW'(i_b);
            r_ia  <= '0;
            r_ib  <= '0;
            r_acc <= '0;
        end else begin
            if (r_run) begin
                if (r_ib == IW'(NL - 1)) begin
                    r_ib <= '0;
                    r_ia <= r_ia + 1'b1;
                end else begin
                    r_ib <= r_ib + 1'b1;
                end
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + (pp_ext << (LIMB_W * r_pp_sh));
            end
        end
        r_pp    <= r_a[LIMB_W*r_ia +: LIMB_W] * r_b[LIMB_W*r_ib +: LIMB_W];
        r_pp_sh <= SW'(r_ia) + SW'(r_ib);
    end

    assign o_done = r_done;
    assign o_prod = r_acc[2*Z_WIDTH-1:0];

endmodule

// ===== rtl/met_core.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath of the escape-time iteration around the shared multiplier.
// Depends on met_pkg and met_mul.
module met_core
    import met_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int Z_WIDTH   = Z_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_met_cfg           i_cfg,
    input  logic               i_start,
    input  logic [C_WIDTH-1:0] i_c_real,
    input  logic [C_WIDTH-1:0] i_c_imag,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_met_res           o_res
);

    localparam int Z   = Z_WIDTH;
    localparam int SHL = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int SHR = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
    localparam int LW  = RSQ_W + 2 * FRAC_BITS;
    localparam int CW  = (2 * Z + 1 > LW) ? 2 * Z + 1 : LW;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQX  = 7'b0000010,
        S_SQY  = 7'b0000100,
        S_XY   = 7'b0001000,
        S_IM   = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    function automatic logic [Z-1:0] mag(input logic [Z-1:0] v);
        mag = v[Z-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [Z-1:0] sat_z(input logic [2*Z:0] v);
        logic same;
        same  = (&v[2*Z:Z-1]) || !(|v[2*Z:Z-1]);
        sat_z = same ? v[Z-1:0] : (v[2*Z] ? {1'b1, {(Z-1){1'b0}}} : {1'b0, {(Z-1){1'b1}}});
    endfunction

    t_state            r_state, n_state;
    logic              r_launch, n_launch;
    logic              r_init, n_init;
    logic              r_esc, n_esc;
    logic [ITER_W-1:0] r_i, n_i;
    logic [Z-1:0]      r_x, n_x;
    logic [Z-1:0]      r_y, n_y;
    logic [Z-1:0]      r_cr, n_cr;
    logic [Z-1:0]      r_ci, n_ci;
    logic [2*Z-1:0]    r_x2, n_x2;
    logic [2*Z-1:0]    r_y2, n_y2;
    logic [2*Z-1:0]    r_re, n_re;
    logic [2*Z:0]      r_im, n_im;

    logic signed [Z-1:0] cr_ext, ci_ext, cr_z, ci_z;
    logic [Z-1:0]        mag_x, mag_y, mul_a, mul_b;
    logic                mul_done;
    logic [2*Z-1:0]      prod;
    logic [2*Z:0]        prod_z;
    logic signed [2*Z:0] re_sh, im_sh;
    logic [2*Z:0]        cr_w, ci_w, re_sum, im_sum;
    logic [2*Z:0]        sq_sum;
    logic [CW-1:0]       limit;
    logic                esc_hit;
    logic [ITER_W-1:0]   i_next;

    assign cr_ext = {{(Z-C_WIDTH){i_c_real[C_WIDTH-1]}}, i_c_real};
    assign ci_ext = {{(Z-C_WIDTH){i_c_imag[C_WIDTH-1]}}, i_c_imag};
    assign cr_z   = (cr_ext <<< SHL) >>> SHR;
    assign ci_z   = (ci_ext <<< SHL) >>> SHR;

    assign mag_x = mag(r_x);
    assign mag_y = mag(r_y);
    assign mul_a = (r_state == S_SQY) ? mag_y : mag_x;
    assign mul_b = (r_state == S_SQX) ? mag_x : mag_y;

    met_mul #(
        .Z_WIDTH(Z_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_launch),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (prod)
    );

    assign prod_z = {1'b0, prod};
    assign re_sh  = $signed({r_re[2*Z-1], r_re}) >>> FRAC_BITS;
    assign im_sh  = $signed(r_im) >>> (FRAC_BITS - 1);
    assign cr_w   = {{(Z+1){r_cr[Z-1]}}, r_cr};
    assign ci_w   = {{(Z+1){r_ci[Z-1]}}, r_ci};
    assign re_sum = re_sh + cr_w;
    assign im_sum = im_sh + ci_w;

    assign sq_sum  = {1'b0, r_x2} + prod_z;
    assign limit   = CW'(i_cfg.radius_sq) << (2 * FRAC_BITS);
    assign esc_hit = CW'(sq_sum) > limit;
    assign i_next  = r_init ? r_i : r_i + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_launch = 1'b0;
        n_init   = r_init;
        n_esc    = r_esc;
        n_i      = r_i;
        n_x      = r_x;
        n_y      = r_y;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_x2     = r_x2;
        n_y2     = r_y2;
        n_re     = r_re;
        n_im     = r_im;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cr     = cr_z;
                    n_ci     = ci_z;
                    n_x      = cr_z;
                    n_y      = ci_z;
                    n_i      = '0;
                    n_init   = 1'b1;
                    n_esc    = 1'b0;
                    n_launch = 1'b1;
                    n_state  = S_SQX;
                end
            end
            S_SQX: begin
                if (mul_done) begin
                    n_x2     = prod;
                    n_launch = 1'b1;
                    n_state  = S_SQY;
                end
            end
            S_SQY: begin
                if (mul_done) begin
                    n_y2   = prod;
                    n_init = 1'b0;
                    if (!r_init && esc_hit) begin
                        n_esc   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_i = i_next;
                        if (i_next == i_cfg.max_iter) begin
                            n_state = S_OUT;
                        end else begin
                            n_launch = 1'b1;
                            n_state  = S_XY;
                        end
                    end
                end
            end
            S_XY: begin
                n_re = r_x2 - r_y2;
                if (mul_done) begin
                    n_im    = (r_x[Z-1] ^ r_y[Z-1]) ? (~prod_z + 1'b1) : prod_z;
                    n_state = S_IM;
                end
            end
            S_IM: begin
                n_x     = sat_z(re_sum);
                n_y     = sat_z(im_sum);
                n_state = S_UPD;
            end
            S_UPD: begin
                n_launch = 1'b1;
                n_state  = S_SQX;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_init   <= 1'b0;
            r_esc    <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_init   <= n_init;
            r_esc    <= n_esc;
            r_i      <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_cr <= n_cr;
        r_ci <= n_ci;
        r_x2 <= n_x2;
        r_y2 <= n_y2;
        r_re <= n_re;
        r_im <= n_im;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_OUT);
    assign o_res.iterations = r_i;
    assign o_res.escaped    = r_esc;

endmodule

// ===== rtl/mandelbrot_escape_time_core.sv =====
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time core: configuration, stream ports, result register.
// Depends on met_pkg, met_core and met_mul.

// One item is a point c in signed Q8.24. Starting from z = c, the core iterates
// z = z*z + c in saturating Q(Z_WIDTH-FRAC_BITS).FRAC_BITS until |z|^2 exceeds the
// squared escape radius or max_iterations rounds have run. All products go through one
// shared multiplier that takes one 32x32 partial product per cycle; each product
// is built from NL*NL partial products, NL being the number of 32-bit limbs of Z_WIDTH.
// A round needs three products (x*x, y*y, x*y) plus the update states S_IM and S_UPD.
// An item is accepted only while the core is idle, and s_axis_tready stays low
// until its result has moved into the output register. Configuration writes are taken
// in every cycle and should only be issued while no item is in flight.
module mandelbrot_escape_time_core
    import met_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int Z_WIDTH   = Z_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // c_real[31:0], c_imag[63:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata   // iterations[14:0], escaped[15]
);

    t_met_cfg r_cfg;
    t_met_res r_m_data;
    logic     r_m_valid;

    t_met_res core_res;
    logic     core_idle;
    logic     core_res_valid;
    logic     res_ready;
    logic     in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter  <= MAX_ITER_RST;
            r_cfg.radius_sq <= RSQ_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_addr == CFG_MAX_ITER) begin
                r_cfg.max_iter <= i_cfg_data[ITER_W-1:0];
            end else if (i_cfg_addr == CFG_RADIUS) begin
                r_cfg.radius_sq <= RSQ_W'(i_cfg_data[RADIUS_W-1:0])
                                 * RSQ_W'(i_cfg_data[RADIUS_W-1:0]);
            end
        end
    end

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = core_idle;
    assign res_ready     = !r_m_valid || m_axis_tready;

    met_core #(
        .FRAC_BITS(FRAC_BITS),
        .Z_WIDTH  (Z_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (in_accept),
        .i_c_real   (s_axis_tdata[31:0]),
        .i_c_imag   (s_axis_tdata[63:32]),
        .o_idle     (core_idle),
        .o_res_valid(core_res_valid),
        .i_res_ready(res_ready),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && core_res_valid) begin
            r_m_data <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_data.escaped, r_m_data.iterations};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_time_core: directed and random points,
// checked against a behavioral escape-time predictor. Depends on met_pkg and the core RTL.
module testbench;
    import met_pkg::*;

    localparam int F  = FRAC_BITS_DEF;
    localparam int ZW = Z_WIDTH_DEF;
    localparam int WIDE = 128;
    localparam int unsigned UNIT = 1 << IN_FRAC;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 1500;
    localparam int RANDOM_PER_SETTING = 36;
    localparam int PRINT_LIMIT = 20;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = CFG_ADDR_W'(9);
    localparam logic signed [WIDE-1:0] Z_HI = (128'sd1 <<< (ZW - 1)) - 128'sd1;
    localparam logic signed [WIDE-1:0] Z_LO = -(128'sd1 <<< (ZW - 1));

    typedef struct {
        logic [C_WIDTH-1:0] c_re;
        logic [C_WIDTH-1:0] c_im;
        t_met_res           res;
    } t_point_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;  // c_real[31:0], c_imag[63:32]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // iterations[14:0], escaped[15]

    logic [ITER_W-1:0]   cfg_max_iter = MAX_ITER_RST;
    logic [RADIUS_W-1:0] cfg_radius = RADIUS_W'(1000);

    t_point_result expected_escapes[$];
    t_point_result head;
    t_met_res      seen_res;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned points_sent = 0;
    int unsigned results_seen = 0;
    int unsigned escapes_seen = 0;
    int unsigned settings_used = 0;

    mandelbrot_escape_time_core #(
        .FRAC_BITS(F),
        .Z_WIDTH  (ZW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [WIDE-1:0] to_z(input logic [C_WIDTH-1:0] c);
        logic signed [WIDE-1:0] v;
        v = signed'(c);
        if (F >= IN_FRAC) return v <<< (F - IN_FRAC);
        return v >>> (IN_FRAC - F);
    endfunction

    function automatic logic signed [WIDE-1:0] clamp_z(input logic signed [WIDE-1:0] v);
        if (v > Z_HI) return Z_HI;
        if (v < Z_LO) return Z_LO;
        return v;
    endfunction

    function automatic t_met_res escape_time(input logic [C_WIDTH-1:0] c_re,
                                             input logic [C_WIDTH-1:0] c_im);
        logic signed [WIDE-1:0] cr, ci, x, y, xn, yn, rad, bound;
        int unsigned k;
        bit esc;
        t_met_res r;
        cr = to_z(c_re);
        ci = to_z(c_im);
        x = cr;
        y = ci;
        rad = {{(WIDE - RADIUS_W){1'b0}}, cfg_radius};
        bound = (rad * rad) <<< (2 * F);
        k = 0;
        esc = 1'b0;
        while (k < cfg_max_iter && !esc) begin
            xn = clamp_z(((x * x - y * y) >>> F) + cr);
            yn = clamp_z(((x * y) >>> (F - 1)) + ci);
            if (xn * xn + yn * yn > bound) begin
                esc = 1'b1;
            end else begin
                x = xn;
                y = yn;
                k++;
            end
        end
        r.iterations = k[ITER_W-1:0];
        r.escaped = esc;
        return r;
    endfunction

    function automatic logic [C_WIDTH-1:0] corner_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return UNIT;
            4: return -UNIT;
            5: return 2 * UNIT;
            6: return -(2 * UNIT);
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    function automatic void pick_point(output logic [C_WIDTH-1:0] c_re,
                                       output logic [C_WIDTH-1:0] c_im);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            c_re = $urandom_range(0, 3 * UNIT) - 9 * UNIT / 4;
            c_im = $urandom_range(0, 3 * UNIT) - 3 * UNIT / 2;
        end else if (sel < 80) begin
            c_re = $urandom;
            c_im = $urandom;
        end else begin
            c_re = corner_value();
            c_im = corner_value();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [C_WIDTH-1:0] c_re,
                                   input logic [C_WIDTH-1:0] c_im, input int unsigned got_v,
                                   input int unsigned want_v);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] %s: got %0d, expected %0d, c = %h + i*%h",
                     $realtime, what, got_v, want_v, c_re, c_im);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            CFG_MAX_ITER: cfg_max_iter = data[ITER_W-1:0];
            CFG_RADIUS:   cfg_radius = data[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] max_iter,
                              input logic [CFG_DATA_W-1:0] radius_word);
        write_reg(CFG_MAX_ITER, max_iter);
        write_reg(CFG_RADIUS, radius_word);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_point(input logic [C_WIDTH-1:0] c_re, input logic [C_WIDTH-1:0] c_im);
        t_point_result entry;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        s_axis_tdata  <= {c_im, c_re};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        entry.c_re = c_re;
        entry.c_im = c_im;
        entry.res = escape_time(c_re, c_im);
        expected_escapes.push_back(entry);
        points_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_escapes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Defaults after reset: two points that never escape and one that escapes at once.
    task automatic test_reset_values();
        send_point('0, '0);
        send_point(-(2 * UNIT), '0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        drain_results();
    endtask

    task automatic test_field_extremes();
        set_limits(8, 2);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        drain_results();
    endtask

    task automatic test_zero_limit();
        set_limits(0, 2);
        send_point('0, '0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain_results();
    endtask

    // With a zero radius, c = 0 stays at the origin while c = -1 passes through it once.
    task automatic test_zero_radius();
        set_limits(16, 0);
        send_point('0, '0);
        send_point(-UNIT, '0);
        send_point(32'h0000_0001, '0);
        drain_results();
    endtask

    task automatic test_single_round();
        set_limits(1, 2);
        send_point(UNIT / 4, '0);
        send_point('0, 3 * UNIT / 2);
        drain_results();
    endtask

    task automatic test_unmapped_index();
        for (int a = CFG_RADIUS + 1; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        send_point(UNIT / 4, UNIT / 4);
        drain_results();
    endtask

    // Max iteration limit, radius 1023 then 1; points outside radius 2 escape quickly.
    task automatic test_limit_extremes();
        set_limits(15'h7FFF, 15'h7FFF);
        send_point(5 * UNIT / 2, '0);
        send_point(-(5 * UNIT / 2), UNIT / 2);
        drain_results();
        set_limits(15'h7FFF, 1);
        send_point(32'h7FFF_FFFF, '0);
        send_point('0, 17 * UNIT / 8);
        drain_results();
    endtask

    task automatic test_backpressure();
        logic [C_WIDTH-1:0] c_re, c_im;
        set_limits(4, 2);
        send_idle_pct = 0;
        hold_left <= LONG_HOLD;
        repeat (10) begin
            pick_point(c_re, c_im);
            send_point(c_re, c_im);
        end
        drain_results();
        repeat (6) begin
            pick_point(c_re, c_im);
            send_point(c_re, c_im);
        end
        drain_results();
    endtask

    task automatic test_random_points();
        logic [C_WIDTH-1:0] c_re, c_im;
        logic [CFG_DATA_W-1:0] mi;
        logic [RADIUS_W-1:0] rad;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int s = 0; s < 4; s++) begin
                case ($urandom_range(0, 3))
                    0: mi = $urandom_range(1, 8);
                    1: mi = $urandom_range(9, 64);
                    2: mi = 64;
                    default: mi = $urandom_range(1, 32);
                endcase
                case ($urandom_range(0, 5))
                    0: rad = 1;
                    1: rad = 2;
                    2: rad = 4;
                    3: rad = 1023;
                    4: rad = $urandom_range(0, 1023);
                    default: rad = $urandom_range(1, 16);
                endcase
                set_limits(mi, {5'($urandom), rad});
                repeat (RANDOM_PER_SETTING) begin
                    pick_point(c_re, c_im);
                    send_point(c_re, c_im);
                end
                drain_results();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_res = m_axis_tdata;
            results_seen++;
            if (seen_res.escaped) escapes_seen++;
            if (expected_escapes.size() == 0) begin
                report_mismatch("result with no point outstanding", '0, '0,
                                seen_res.iterations, 0);
            end else begin
                head = expected_escapes.pop_front();
                if (seen_res.iterations !== head.res.iterations)
                    report_mismatch("iterations", head.c_re, head.c_im,
                                    seen_res.iterations, head.res.iterations);
                if (seen_res.escaped !== head.res.escaped)
                    report_mismatch("escaped", head.c_re, head.c_im,
                                    seen_res.escaped, head.res.escaped);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_escapes.size());
            $display("FAIL mandelbrot_escape_time_core");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 20;
        recv_stall_pct = 20;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_field_extremes();
        test_zero_limit();
        test_zero_radius();
        test_single_round();
        test_unmapped_index();
        test_limit_extremes();
        test_backpressure();
        test_random_points();
        drain_results();
        if (expected_escapes.size() != 0) begin
            error_count++;
            $display("%0d results never arrived.", expected_escapes.size());
        end
        $display("Sent %0d points and checked %0d results, %0d of them escaped.",
                 points_sent, results_seen, escapes_seen);
        $display("Covered %0d limit settings, unmapped register writes and %0d cycles.",
                 settings_used, cycle_count);
        if (error_count == 0) begin
            $display("PASS mandelbrot_escape_time_core");
        end else begin
            $display("FAIL mandelbrot_escape_time_core");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/met_pkg.sv
rtl/met_mul.sv
rtl/met_core.sv
rtl/mandelbrot_escape_time_core.sv
tb/testbench.sv
